@@ rtl/core/mkd_pkg.sv @@
// Shared types, constants and helpers for the multi-key debouncer.
package mkd_pkg;

  // Fixed field widths of the sample, result and configuration beats.
  localparam int RAW_W  = 3;
  localparam int LEN_W  = 6;
  localparam int CNT_W  = 8;
  localparam int CFG_AW = 3;
  localparam int CFG_DW = 32;

  // Debounce length after reset.
  localparam logic [LEN_W-1:0] LEN_RESET = 6'd4;

  // Register index, taken from the word address of the configuration port.
  typedef enum logic [0:0] {
    REG_DEBOUNCE_TICKS = 1'b0
  } mkd_reg_idx_t;

  // Signed bounce counter of one key.
  typedef logic signed [CNT_W-1:0] mkd_cnt_t;

  // Control shared by every key cell.
  typedef struct packed {
    logic             step;
    logic             restart;
    logic [LEN_W-1:0] len;
  } mkd_cell_ctrl_t;

  // A zero debounce length behaves as a length of one.
  function automatic logic [LEN_W-1:0] active_len(input logic [LEN_W-1:0] len);
    logic [LEN_W-1:0] res;
    res = (len == '0) ? LEN_W'(1) : len;
    return res;
  endfunction

endpackage

@@ rtl/core/mkd_cfg_regs.sv @@
// Configuration register file holding the debounce length.
module mkd_cfg_regs
  import mkd_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready,
  output logic [LEN_W-1:0]  len
);

  logic [LEN_W-1:0] len_r;
  logic [LEN_W-1:0] len_nxt;
  mkd_reg_idx_t     reg_idx;
  logic             wr_en;

  // The word address selects the register; byte offsets are ignored.
  assign reg_idx = mkd_reg_idx_t'(paddr[CFG_AW-1]);
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  // Write decode.
  always_comb begin
    len_nxt = len_r;
    if (wr_en && (reg_idx == REG_DEBOUNCE_TICKS)) begin
      len_nxt = pwdata[LEN_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= LEN_RESET;
    end else begin
      len_r <= len_nxt;
    end
  end

  // Read-back mux.
  always_comb begin
    unique case (reg_idx)
      REG_DEBOUNCE_TICKS: prdata = {{(CFG_DW-LEN_W){1'b0}}, len_r};
      default:            prdata = '0;
    endcase
  end

  assign len = len_r;

endmodule

@@ rtl/core/mkd_key_cell.sv @@
// Debounce counter and debounced level of a single key.
module mkd_key_cell
  import mkd_pkg::*;
(
  input  logic           clk,
  input  logic           rst_n,
  input  mkd_cell_ctrl_t ctrl,
  input  logic           raw_bit,
  output logic           level_q,
  output logic           level_nxt,
  output logic           changed
);

  mkd_cnt_t         cnt_r;
  mkd_cnt_t         cnt_nxt;
  mkd_cnt_t         d_s;
  mkd_cnt_t         two_d;
  mkd_cnt_t         stepped;
  logic             level_r;
  logic [LEN_W-1:0] len_a;

  // Start value and false-alarm limit from the current length.
  assign len_a   = active_len(ctrl.len);
  assign d_s     = mkd_cnt_t'({2'b00, len_a});
  assign two_d   = mkd_cnt_t'({1'b0, len_a, 1'b0});
  // A released sample counts up, a pressed sample counts down.
  assign stepped = raw_bit ? (cnt_r + mkd_cnt_t'(1)) : (cnt_r - mkd_cnt_t'(1));

  // Counter and level update for one sample.
  always_comb begin
    cnt_nxt   = cnt_r;
    level_nxt = level_r;
    changed   = 1'b0;
    priority if (ctrl.restart) begin
      cnt_nxt   = '0;
      level_nxt = 1'b1;
    end else if (cnt_r == '0) begin
      if (raw_bit && !level_r) begin
        cnt_nxt = -d_s;
      end else if (!raw_bit && level_r) begin
        cnt_nxt = d_s;
      end
    end else if (stepped == '0) begin
      cnt_nxt   = '0;
      level_nxt = raw_bit;
      changed   = 1'b1;
    end else if ((stepped >= two_d) || (stepped <= -two_d)) begin
      cnt_nxt = '0;
    end else begin
      cnt_nxt = stepped;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= '0;
      level_r <= 1'b1;
    end else if (ctrl.step) begin
      cnt_r   <= cnt_nxt;
      level_r <= level_nxt;
    end
  end

  assign level_q = level_r;

  // A stored count never leaves the band of the longest debounce length.
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r <= mkd_cnt_t'(125)) && (cnt_r >= -mkd_cnt_t'(125)))
    else $error("bounce counter out of range");

endmodule

@@ rtl/core/multi_key_counter_debouncer_top.sv @@
// Top level of the multi-key counter debouncer: beat registers and key cells.
// A sample beat is held in the input beat register, then its result in the result beat register.
// Throughput: one sample beat per cycle while results are taken; the key cells compute their update combinationally.
// A full result register that is not taken holds back one further sample only.
// Reset (synchronous, rst_n low): pipeline empty, all keys released,
// counters zero, debounce length 4.
module multi_key_counter_debouncer_top
  import mkd_pkg::*;
#(
  parameter int KEY_COUNT = 3
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [RAW_W-1:0]  in_raw_levels,
  input  logic              in_restart,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [RAW_W-1:0]  out_key_levels,
  output logic              out_changed,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready
);

  logic                 s1_v_r;
  logic [RAW_W-1:0]     s1_raw_r;
  logic                 s1_restart_r;
  logic                 out_v_r;
  logic [RAW_W-1:0]     out_key_levels_r;
  logic [RAW_W-1:0]     out_key_levels_nxt;
  logic                 out_changed_r;
  logic                 adv;
  logic [LEN_W-1:0]     len;
  logic [KEY_COUNT-1:0] lvl_q;
  logic [KEY_COUNT-1:0] lvl_nxt;
  logic [KEY_COUNT-1:0] chg;
  mkd_cell_ctrl_t       cell_ctrl;

  // The input register moves on whenever the result register is free.
  assign adv      = s1_v_r && (!out_v_r || out_ready);
  assign in_ready = !s1_v_r || adv;

  // Input beat register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_ready) begin
      s1_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_raw_r     <= in_raw_levels;
      s1_restart_r <= in_restart;
    end
  end

  mkd_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .len     (len)
  );

  assign cell_ctrl.step    = adv;
  assign cell_ctrl.restart = s1_restart_r;
  assign cell_ctrl.len     = len;

  // One cell per key; keys beyond the sample width always see a pressed sample.
  for (genvar k = 0; k < KEY_COUNT; k++) begin : g_key
    logic raw_bit;
    if (k < RAW_W) begin : g_sampled
      assign raw_bit = s1_raw_r[k];
    end else begin : g_unsampled
      assign raw_bit = 1'b0;
    end
    mkd_key_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctrl      (cell_ctrl),
      .raw_bit   (raw_bit),
      .level_q   (lvl_q[k]),
      .level_nxt (lvl_nxt[k]),
      .changed   (chg[k])
    );
  end

  // Result levels: only the keys that fit in the result field are shown.
  for (genvar b = 0; b < RAW_W; b++) begin : g_out
    if (b < KEY_COUNT) begin : g_key_bit
      assign out_key_levels_nxt[b] = lvl_nxt[b];
    end else begin : g_pad_bit
      assign out_key_levels_nxt[b] = 1'b0;
    end
  end

  // Result beat register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (adv) begin
      out_v_r <= 1'b1;
    end else if (out_ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_key_levels_r <= out_key_levels_nxt;
      out_changed_r    <= |chg;
    end
  end

  assign out_valid      = out_v_r;
  assign out_key_levels = out_key_levels_r;
  assign out_changed    = out_changed_r;

  // A restart sample yields all shown keys released and no change.
  a_restart_result: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && s1_restart_r) |=> (out_valid && !out_changed))
    else $error("restart result carries a change flag");

  // A flagged change always moves at least one debounced level.
  a_change_moves_level: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && (|chg)) |-> (lvl_nxt != lvl_q))
    else $error("change flagged without a level change");

  // Keys only change level when a sample beat is processed.
  a_level_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(lvl_q))
    else $error("debounced level moved without a sample beat");

endmodule
